// File: hw/rtl/pde_pkg.sv
package pde_pkg;

  // Default number of jobs held between the front and the back.
  localparam int QUEUE_DEPTH_DEF = 2;

  // Characters that the decoder and the escaper look for.
  localparam logic [7:0] CHAR_PCT  = 8'h25;
  localparam logic [7:0] CHAR_LT   = 8'h3C;
  localparam logic [7:0] CHAR_GT   = 8'h3E;
  localparam logic [7:0] CHAR_AMP  = 8'h26;
  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_L    = 8'h6C;
  localparam logic [7:0] CHAR_G    = 8'h67;
  localparam logic [7:0] CHAR_T    = 8'h74;
  localparam logic [7:0] CHAR_A    = 8'h61;
  localparam logic [7:0] CHAR_M    = 8'h6D;
  localparam logic [7:0] CHAR_P    = 8'h70;

  // What the middle part of one job emits.
  typedef enum logic [2:0] {
    BODY_NONE,
    BODY_RAW,
    BODY_LT,
    BODY_GT,
    BODY_AMP,
    BODY_NUL
  } body_t;

  // One job: a literal lead ("%" or "%" and a digit), a body, then a literal
  // trail that flushes what was pending at the end of a string.
  typedef struct packed {
    logic [1:0] lead_n;
    body_t      body;
    logic [7:0] body_byte;
    logic [7:0] digit;
    logic [2:0] len;
    logic       last;
  } job_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  // Only meaningful for hex digit characters.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    if (c <= 8'h39) begin
      hex_val = c[3:0];
    end else begin
      hex_val = c[3:0] + 4'd9;
    end
  endfunction

  function automatic body_t classify(input logic [7:0] b);
    if (b == CHAR_LT) begin
      classify = BODY_LT;
    end else if (b == CHAR_GT) begin
      classify = BODY_GT;
    end else if (b == CHAR_AMP) begin
      classify = BODY_AMP;
    end else if (b == CHAR_NUL) begin
      classify = BODY_NUL;
    end else begin
      classify = BODY_RAW;
    end
  endfunction

  function automatic logic [2:0] body_len(input body_t k);
    case (k)
      BODY_NONE: body_len = 3'd0;
      BODY_RAW:  body_len = 3'd1;
      BODY_LT:   body_len = 3'd4;
      BODY_GT:   body_len = 3'd4;
      BODY_AMP:  body_len = 3'd5;
      BODY_NUL:  body_len = 3'd5;
      default:   body_len = 3'd0;
    endcase
  endfunction

  // Character at position idx of the body text.
  function automatic logic [7:0] body_char(input body_t k, input logic [7:0] b,
                                           input logic [2:0] idx);
    logic [7:0] c;
    c = CHAR_AMP;
    case (k)
      BODY_RAW: c = b;
      BODY_LT: begin
        case (idx)
          3'd0:    c = CHAR_AMP;
          3'd1:    c = CHAR_L;
          3'd2:    c = CHAR_T;
          default: c = CHAR_SEMI;
        endcase
      end
      BODY_GT: begin
        case (idx)
          3'd0:    c = CHAR_AMP;
          3'd1:    c = CHAR_G;
          3'd2:    c = CHAR_T;
          default: c = CHAR_SEMI;
        endcase
      end
      BODY_AMP: begin
        case (idx)
          3'd0:    c = CHAR_AMP;
          3'd1:    c = CHAR_A;
          3'd2:    c = CHAR_M;
          3'd3:    c = CHAR_P;
          default: c = CHAR_SEMI;
        endcase
      end
      BODY_NUL: begin
        case (idx)
          3'd0:    c = CHAR_AMP;
          3'd1:    c = CHAR_HASH;
          3'd2:    c = CHAR_ZERO;
          3'd3:    c = CHAR_ZERO;
          default: c = CHAR_SEMI;
        endcase
      end
      default: c = b;
    endcase
    body_char = c;
  endfunction

endpackage

// File: hw/rtl/pde_in_if.sv
interface pde_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// File: hw/rtl/pde_out_if.sv
interface pde_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_end;

  modport source (output valid, output out_byte, output run_last, output string_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input string_end,
                output ready);
endinterface

// File: hw/rtl/pde_front.sv
module pde_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              q_ready,
  output logic              push,
  output pde_pkg::job_t     job
);

  logic [1:0]     pend_r, pend_nxt;
  logic [7:0]     digit_r, digit_nxt;
  logic           decode_r;
  logic           acc;
  logic           fresh;
  logic           hexin;
  logic [1:0]     lead_n;
  logic [1:0]     trail_n;
  logic [1:0]     pend_after;
  pde_pkg::body_t body;
  logic [7:0]     body_byte;
  logic [7:0]     dec_byte;

  assign acc   = in_valid && q_ready;
  assign hexin = pde_pkg::is_hex(in_byte);
  assign dec_byte = {pde_pkg::hex_val(digit_r), pde_pkg::hex_val(in_byte)};

  // Classify the word against the pending escape state.
  always_comb begin
    lead_n     = 2'd0;
    fresh      = 1'b0;
    pend_after = 2'd0;
    digit_nxt  = digit_r;
    body       = pde_pkg::BODY_NONE;
    body_byte  = in_byte;
    case (pend_r)
      2'd1: begin
        if (hexin) begin
          pend_after = 2'd2;
          digit_nxt  = in_byte;
        end else begin
          lead_n = 2'd1;
          fresh  = 1'b1;
        end
      end
      2'd2: begin
        if (hexin) begin
          body      = pde_pkg::classify(dec_byte);
          body_byte = dec_byte;
        end else begin
          lead_n = 2'd2;
          fresh  = 1'b1;
        end
      end
      default: fresh = 1'b1;
    endcase
    if (fresh) begin
      if (decode_r && in_byte == pde_pkg::CHAR_PCT) begin
        pend_after = 2'd1;
      end else begin
        body = pde_pkg::classify(in_byte);
      end
    end
    trail_n  = in_last ? pend_after : 2'd0;
    pend_nxt = in_last ? 2'd0 : pend_after;
  end

  // Build the job; a lead with a digit never meets a trail with a digit.
  always_comb begin
    job.lead_n    = lead_n;
    job.body      = body;
    job.body_byte = body_byte;
    job.digit     = (lead_n == 2'd2) ? digit_r : digit_nxt;
    job.len       = {1'b0, lead_n} + pde_pkg::body_len(body) + {1'b0, trail_n};
    job.last      = in_last;
    push          = acc && (job.len != 3'd0);
  end

  // Pending state and the decode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 2'd0;
      decode_r <= 1'b1;
    end else begin
      if (acc) begin
        pend_r <= pend_nxt;
      end
      if (cfg_we) begin
        decode_r <= cfg_wdata;
      end
    end
  end

  // The held digit is payload only.
  always_ff @(posedge clk) begin
    if (acc) begin
      digit_r <= digit_nxt;
    end
  end

endmodule

// File: hw/rtl/pde_queue.sv
module pde_queue #(
  parameter int QUEUE_DEPTH = pde_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pde_pkg::job_t push_job,
  output logic          q_ready,
  input  logic          pop,
  output logic          head_valid,
  output pde_pkg::job_t head_job
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  pde_pkg::job_t entries_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign q_ready    = (count_r != CW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = entries_r[rd_ptr_r];
  assign do_push    = push && q_ready;
  assign do_pop     = pop && head_valid;

  // Pointer and count updates with wraparound.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: hw/rtl/pde_back.sv
module pde_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  pde_pkg::job_t head_job,
  output logic          pop,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [7:0]    out_byte,
  output logic          run_last,
  output logic          string_end
);

  logic [2:0] pos_r, pos_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       run_last_r, string_end_r;
  logic       load;
  logic       fin;
  logic [2:0] blen;
  logic [2:0] rel;
  logic [2:0] rel_trail;
  logic [7:0] cur_byte;

  assign load = head_valid && (!out_valid_r || out_ready);
  assign fin  = (pos_r == head_job.len - 3'd1);
  assign pop  = load && fin;
  assign blen = pde_pkg::body_len(head_job.body);
  assign rel  = pos_r - {1'b0, head_job.lead_n};
  assign rel_trail = rel - blen;

  // Select the byte at the current position of the head job.
  always_comb begin
    if (pos_r < {1'b0, head_job.lead_n}) begin
      cur_byte = (pos_r == 3'd0) ? pde_pkg::CHAR_PCT : head_job.digit;
    end else if (rel < blen) begin
      cur_byte = pde_pkg::body_char(head_job.body, head_job.body_byte, rel);
    end else begin
      cur_byte = (rel_trail == 3'd0) ? pde_pkg::CHAR_PCT : head_job.digit;
    end
  end

  // Position and output-valid next values.
  always_comb begin
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      pos_nxt       = fin ? 3'd0 : pos_r + 3'd1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r   <= cur_byte;
      run_last_r   <= fin;
      string_end_r <= fin && head_job.last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign run_last   = run_last_r;
  assign string_end = string_end_r;

endmodule

// File: hw/rtl/percent_decode_xml_escape_unit.sv
// Channel   Dir  Word                          Handshake
// in_ch     in   in_byte[7:0], in_last         valid / ready
// out_ch    out  out_byte[7:0], run_last,       valid / ready
//                string_end
// cfg_*     in   cfg_wdata = decode_percent    cfg_we, no wait
//
// An input word is accepted whenever the job queue has room, so words that give
// at most one output byte stream at one per cycle while the output is ready. A
// word that expands to n bytes holds the single output register for each of them
// and stays in the QUEUE_DEPTH-entry job queue until its last byte is loaded;
// later words fill the queue and then stall the input. With an idle back end the
// first output byte of a word passes through a queue entry and then the output
// register. Reset is synchronous and clears pending state, queue and output
// valid; decode_percent resets to 1.
module percent_decode_xml_escape_unit #(
  parameter int QUEUE_DEPTH = pde_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  pde_in_if.sink    in_ch,
  pde_out_if.source out_ch
);

  logic          push;
  logic          q_ready;
  logic          pop;
  logic          head_valid;
  pde_pkg::job_t push_job;
  pde_pkg::job_t head_job;

  assign in_ch.ready = q_ready;

  // Front: decode state and classification.
  pde_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_ch.valid),
    .in_byte   (in_ch.in_byte),
    .in_last   (in_ch.in_last),
    .q_ready   (q_ready),
    .push      (push),
    .job       (push_job)
  );

  // Queue of jobs between the two sides.
  pde_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .q_ready    (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Back: byte sequencer and output register.
  pde_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_byte   (out_ch.out_byte),
    .run_last   (out_ch.run_last),
    .string_end (out_ch.string_end)
  );

endmodule

// File: hw/rtl/pde_checker.sv
module pde_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       string_end
);

  // A stalled output word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
    $stable(run_last) && $stable(string_end))
    else $error("output word changed while stalled");

  // The end of a string always closes the run of its word.
  a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !string_end || run_last)
    else $error("string_end without run_last");

  // A NUL byte is always escaped, never emitted raw.
  a_no_nul: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte != 8'h00)
    else $error("raw NUL on output");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind percent_decode_xml_escape_unit pde_checker u_pde_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .run_last   (out_ch.run_last),
  .string_end (out_ch.string_end)
);

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 120;

  // Opening strings, {in_last, in_byte} per word.
  localparam logic [8:0] OPENING [25] = '{
    {1'b0, pde_pkg::CHAR_NUL}, {1'b1, 8'hFF}, {1'b0, pde_pkg::CHAR_LT},
    {1'b0, pde_pkg::CHAR_GT}, {1'b1, pde_pkg::CHAR_AMP},
    {1'b0, pde_pkg::CHAR_PCT}, {1'b0, 8'h33}, {1'b0, 8'h63},
    {1'b0, pde_pkg::CHAR_PCT}, {1'b0, 8'h32}, {1'b0, 8'h35}, {1'b0, 8'h34}, {1'b1, 8'h31},
    {1'b0, pde_pkg::CHAR_PCT}, {1'b0, pde_pkg::CHAR_PCT}, {1'b0, 8'h41}, {1'b0, 8'h66},
    {1'b0, pde_pkg::CHAR_PCT}, {1'b0, 8'h34}, {1'b1, pde_pkg::CHAR_AMP},
    {1'b1, pde_pkg::CHAR_PCT},
    {1'b0, pde_pkg::CHAR_PCT}, {1'b1, 8'h45},
    {1'b0, pde_pkg::CHAR_PCT}, {1'b0, 8'h34}
  };

  localparam logic [7:0] MARKUP [4] = '{pde_pkg::CHAR_LT, pde_pkg::CHAR_GT,
                                        pde_pkg::CHAR_AMP, pde_pkg::CHAR_NUL};

  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
    logic       str_end;
  } xml_word_t;

  // Tracks the decoder state and queues the escaped text that each input word
  // should produce, then checks output words against it in order.
  class escape_scoreboard;
    bit         decode_on;
    bit [1:0]   pend_cnt;
    logic [7:0] pend_digit;
    xml_word_t  expected_q[$];
    logic [7:0] text[$];
    int         mismatches;
    int         words_in;

    function new();
      decode_on  = 1'b1;
      pend_cnt   = 2'd0;
      pend_digit = 8'h00;
      mismatches = 0;
      words_in   = 0;
    endfunction

    static function bit is_hex_digit(logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
    endfunction

    static function logic [3:0] nibble_of(logic [7:0] c);
      logic [7:0] v;
      if (c <= 8'h39) begin
        v = c - 8'h30;
      end else if (c >= 8'h61) begin
        v = c - 8'h61 + 8'd10;
      end else begin
        v = c - 8'h41 + 8'd10;
      end
      return v[3:0];
    endfunction

    function void set_decode(bit v);
      decode_on = v;
    endfunction

    function void put_escaped(logic [7:0] c);
      case (c)
        pde_pkg::CHAR_LT: begin
          text = {text, pde_pkg::CHAR_AMP, pde_pkg::CHAR_L, pde_pkg::CHAR_T,
                  pde_pkg::CHAR_SEMI};
        end
        pde_pkg::CHAR_GT: begin
          text = {text, pde_pkg::CHAR_AMP, pde_pkg::CHAR_G, pde_pkg::CHAR_T,
                  pde_pkg::CHAR_SEMI};
        end
        pde_pkg::CHAR_AMP: begin
          text = {text, pde_pkg::CHAR_AMP, pde_pkg::CHAR_A, pde_pkg::CHAR_M,
                  pde_pkg::CHAR_P, pde_pkg::CHAR_SEMI};
        end
        pde_pkg::CHAR_NUL: begin
          text = {text, pde_pkg::CHAR_AMP, pde_pkg::CHAR_HASH, pde_pkg::CHAR_ZERO,
                  pde_pkg::CHAR_ZERO, pde_pkg::CHAR_SEMI};
        end
        default: text.push_back(c);
      endcase
    endfunction

    // A percent sign only opens a sequence while decoding is on.
    function void put_fresh(logic [7:0] c);
      if (decode_on && c == pde_pkg::CHAR_PCT) begin
        pend_cnt = 2'd1;
      end else begin
        put_escaped(c);
      end
    endfunction

    function void note_input(logic [7:0] c, logic is_end);
      int n;
      text.delete();
      words_in++;
      case (pend_cnt)
        2'd1: begin
          if (is_hex_digit(c)) begin
            pend_cnt   = 2'd2;
            pend_digit = c;
          end else begin
            text.push_back(pde_pkg::CHAR_PCT);
            pend_cnt = 2'd0;
            put_fresh(c);
          end
        end
        2'd2: begin
          if (is_hex_digit(c)) begin
            put_escaped({nibble_of(pend_digit), nibble_of(c)});
            pend_cnt = 2'd0;
          end else begin
            text.push_back(pde_pkg::CHAR_PCT);
            text.push_back(pend_digit);
            pend_cnt = 2'd0;
            put_fresh(c);
          end
          if (pend_cnt == 2'd0) begin
            pend_digit = 8'h00;
          end
        end
        default: put_fresh(c);
      endcase
      // The end of a string flushes whatever is still held, literally.
      if (is_end) begin
        if (pend_cnt >= 2'd1) begin
          text.push_back(pde_pkg::CHAR_PCT);
        end
        if (pend_cnt == 2'd2) begin
          text.push_back(pend_digit);
        end
        pend_cnt   = 2'd0;
        pend_digit = 8'h00;
      end
      n = text.size();
      foreach (text[i]) begin
        expected_q.push_back('{text[i], i == n - 1, (i == n - 1) && is_end});
      end
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t mismatch: %s", $time, what);
      end
    endfunction

    function void check_result(logic [7:0] ch, logic run_end, logic str_end);
      xml_word_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected word %02h run_last=%0b string_end=%0b",
                         ch, run_end, str_end));
        return;
      end
      want = expected_q.pop_front();
      if (want.ch !== ch || want.run_end !== run_end || want.str_end !== str_end) begin
        report($sformatf("expected %02h/%0b/%0b, got %02h/%0b/%0b (byte/run_last/string_end)",
                         want.ch, want.run_end, want.str_end, ch, run_end, str_end));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  int   idle_cycles;

  pde_in_if  in_ch ();
  pde_out_if out_ch ();

  escape_scoreboard sb = new();

  percent_decode_xml_escape_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Check every word that leaves the block.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.out_byte, out_ch.run_last, out_ch.string_end);
    end
  end

  // Watchdog on cycles in which neither side moves a word.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random back-pressure with long ready stretches, and one long
  // hold-off so that the job queue fills and the input stalls.
  initial begin : drain
    int  run;
    int  held;
    int  r;
    bit  pressure_done;
    out_ch.ready  = 1'b0;
    run           = 0;
    pressure_done = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!pressure_done && sb.words_in >= 40) begin
        pressure_done = 1'b1;
        out_ch.ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
        run = 0;
      end else if (run > 0) begin
        run--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_ch.ready <= 1'b1;
          run = $urandom_range(0, 20);
        end else if (r < 88) begin
          out_ch.ready <= 1'b0;
          run = $urandom_range(0, 2);
        end else begin
          out_ch.ready <= 1'b0;
          run = $urandom_range(5, 25);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_hex();
    string digits;
    digits = "0123456789ABCDEFabcdef";
    return digits[$urandom_range(0, 21)];
  endfunction

  function automatic logic [7:0] rand_nonhex();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (escape_scoreboard::is_hex_digit(c)) begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  // Offer one word and hold it until the block takes it.
  task automatic send_word(input logic [7:0] c, input logic is_end, input int gap);
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= c;
    in_ch.in_last <= is_end;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    sb.note_input(c, is_end);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Builds a string mostly from well-formed escapes and plain text, with some
  // markup, broken sequences, raw bytes and open sequences mixed in.
  task automatic make_string(ref logic [7:0] s[$]);
    int parts;
    int kind;
    s.delete();
    parts = $urandom_range(1, 5);
    repeat (parts) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        s.push_back(8'($urandom_range(32, 126)));
      end else if (kind < 55) begin
        s = {s, pde_pkg::CHAR_PCT, rand_hex(), rand_hex()};
      end else if (kind < 65) begin
        s.push_back(MARKUP[$urandom_range(0, 3)]);
      end else if (kind < 75) begin
        s.push_back(pde_pkg::CHAR_PCT);
        if ($urandom_range(0, 1) == 1) begin
          s.push_back(rand_hex());
        end
        s.push_back(rand_nonhex());
      end else if (kind < 92) begin
        s.push_back(8'($urandom_range(0, 255)));
      end else begin
        s.push_back(pde_pkg::CHAR_PCT);
        if ($urandom_range(0, 1) == 1) begin
          s.push_back(rand_hex());
        end
      end
    end
  endtask

  task automatic run_strings(input int n_words);
    logic [7:0] s[$];
    int         sent;
    bit         burst;
    sent = 0;
    while (sent < n_words) begin
      make_string(s);
      burst = ($urandom_range(0, 4) == 0);
      foreach (s[i]) begin
        send_word(s[i], i == s.size() - 1, burst ? 0 : pick_gap());
      end
      sent += s.size();
    end
  endtask

  // Stop offering, wait for the expected text to drain, then let the block
  // finish any word that gives no output.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_decode(input bit v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_decode(v);
  endtask

  initial begin : stimulus
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;
    idle_cycles   = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Decoding on from reset: extremes, markup, escapes, broken and open
    // sequences. The last two words leave a sequence open across the write.
    foreach (OPENING[i]) begin
      send_word(OPENING[i][7:0], OPENING[i][8], pick_gap());
    end
    settle();
    write_decode(1'b0);

    // The open sequence still completes with decoding off; new ones pass.
    send_word(8'h31, 1'b0, pick_gap());
    send_word(pde_pkg::CHAR_PCT, 1'b0, pick_gap());
    send_word(8'h34, 1'b0, pick_gap());
    send_word(8'h31, 1'b1, pick_gap());
    run_strings(25);
    settle();

    write_decode(1'b1);
    run_strings(40);
    settle();

    write_decode(1'b0);
    run_strings(25);
    settle();

    write_decode(1'b1);
    run_strings(30);
    settle();

    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
